// ===== hdl/fsq_pkg.sv =====
package fsq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int KEY_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_PUSH_TAIL = 2'd0,
        OP_PUSH_ORD  = 2'd1,
        OP_POP       = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // broadcast to every cell, already gated by accept and full/empty
    typedef struct packed {
        logic push_tail;
        logic push_ord;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== hdl/fsq_cell.sv =====
module fsq_cell
    import fsq_pkg::*;
#(
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic                    i_found,
    input  logic                    i_left_occ,
    input  logic [KEY_BITS-1:0]     i_left_key,
    input  logic [PAYLOAD_BITS-1:0] i_left_payload,
    input  logic                    i_right_occ,
    input  logic [KEY_BITS-1:0]     i_right_key,
    input  logic [PAYLOAD_BITS-1:0] i_right_payload,
    output logic                    o_found,
    output logic                    o_occ,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_payload
);

    logic                    r_occ;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic                    n_occ;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] n_payload;
    logic                    gt;
    logic                    at_tail;

    assign gt      = r_occ && (i_key < r_key);
    assign at_tail = !r_occ && i_left_occ;
    assign o_found = i_found || gt;

    always_comb begin
        n_occ     = r_occ;
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctl.push_tail) begin
            n_occ = r_occ || i_left_occ;
            if (at_tail) begin
                n_key     = i_key;
                n_payload = i_payload;
            end
        end else if (i_ctl.push_ord) begin
            n_occ = r_occ || i_left_occ;
            if (i_found) begin
                if (r_occ || i_left_occ) begin
                    n_key     = i_left_key;
                    n_payload = i_left_payload;
                end
            end else if (gt || at_tail) begin
                n_key     = i_key;
                n_payload = i_payload;
            end
        end else if (i_ctl.pop) begin
            n_occ     = i_right_occ;
            n_key     = i_right_key;
            n_payload = i_right_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_occ     = r_occ;
    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

// ===== hdl/fifo_and_sorted_insert_queue_unit.sv =====
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle while o_ready is high; every cell shifts, loads or holds in the same
// cycle, and the ordered-push position ripples through the cell found chain.
// Reset: synchronous, active low; clears the occupancy bits, the count and the
// output valid. Stored keys and payloads are not reset.
module fifo_and_sorted_insert_queue_unit
    import fsq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_op,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_job_valid,
    output logic [KEY_BITS-1:0]     o_job_key,
    output logic [PAYLOAD_BITS-1:0] o_job_payload,
    output logic [CW-1:0]           o_entries,
    output logic                    o_is_empty,
    output logic [1:0]              o_status
);

    logic [DEPTH-1:0]        occ;
    logic [DEPTH-1:0]        found;
    logic [KEY_BITS-1:0]     cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];

    t_op       op;
    t_cell_ctl ctl;
    logic      accept;
    logic      full;
    logic      empty;

    logic                    r_out_valid;
    logic                    r_job_valid;
    logic [KEY_BITS-1:0]     r_job_key;
    logic [PAYLOAD_BITS-1:0] r_job_payload;
    logic [CW-1:0]           r_count;
    t_status                 r_status;

    logic                    n_job_valid;
    logic [KEY_BITS-1:0]     n_job_key;
    logic [PAYLOAD_BITS-1:0] n_job_payload;
    logic [CW-1:0]           n_count;
    t_status                 n_status;

    assign op      = t_op'(i_op);
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = occ[DEPTH-1];
    assign empty   = !occ[0];

    assign ctl.push_tail = accept && (op == OP_PUSH_TAIL) && !full;
    assign ctl.push_ord  = accept && (op == OP_PUSH_ORD) && !full;
    assign ctl.pop       = accept && (op == OP_POP) && !empty;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                    left_occ;
        logic                    left_found;
        logic [KEY_BITS-1:0]     left_key;
        logic [PAYLOAD_BITS-1:0] left_pay;
        logic                    right_occ;
        logic [KEY_BITS-1:0]     right_key;
        logic [PAYLOAD_BITS-1:0] right_pay;

        if (g == 0) begin : g_head
            assign left_occ   = 1'b1;
            assign left_found = 1'b0;
            assign left_key   = '0;
            assign left_pay   = '0;
        end else begin : g_mid
            assign left_occ   = occ[g-1];
            assign left_found = found[g-1];
            assign left_key   = cell_key[g-1];
            assign left_pay   = cell_pay[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_occ = 1'b0;
            assign right_key = '0;
            assign right_pay = '0;
        end else begin : g_inner
            assign right_occ = occ[g+1];
            assign right_key = cell_key[g+1];
            assign right_pay = cell_pay[g+1];
        end

        fsq_cell #(
            .KEY_BITS    (KEY_BITS),
            .PAYLOAD_BITS(PAYLOAD_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_key          (i_key),
            .i_payload      (i_payload),
            .i_found        (left_found),
            .i_left_occ     (left_occ),
            .i_left_key     (left_key),
            .i_left_payload (left_pay),
            .i_right_occ    (right_occ),
            .i_right_key    (right_key),
            .i_right_payload(right_pay),
            .o_found        (found[g]),
            .o_occ          (occ[g]),
            .o_key          (cell_key[g]),
            .o_payload      (cell_pay[g])
        );
    end

    always_comb begin
        n_job_valid   = 1'b0;
        n_job_key     = '0;
        n_job_payload = '0;
        n_count       = r_count;
        n_status      = ST_OK;
        case (op)
            OP_PUSH_TAIL, OP_PUSH_ORD: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_job_valid   = 1'b1;
                    n_job_key     = cell_key[0];
                    n_job_payload = cell_pay[0];
                    if (op == OP_POP) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_job_valid   <= n_job_valid;
            r_job_key     <= n_job_key;
            r_job_payload <= n_job_payload;
            r_status      <= n_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_job_valid   = r_job_valid;
    assign o_job_key     = r_job_key;
    assign o_job_payload = r_job_payload;
    assign o_entries     = r_count;
    assign o_is_empty    = (r_count == '0);
    assign o_status      = r_status;

`ifndef NO_ASSERTIONS
    a_count_matches_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(occ) == int'(r_count))
        else $error("count differs from occupied cells");

    a_occ_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((occ + DEPTH'(1)) & occ) == '0)
        else $error("occupied cells not contiguous from head");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not decrement count");

    a_refused_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (op == OP_PUSH_TAIL || op == OP_PUSH_ORD))
            |=> ($stable(occ) && r_status == ST_FULL))
        else $error("refused push changed the queue");
`endif

endmodule

// ===== tb/sv/tb_fifo_and_sorted_insert_queue_unit.sv =====
module tb_fifo_and_sorted_insert_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fsq_pkg::*;

    localparam int DEPTH    = DEPTH_DEF;
    localparam int KW       = KEY_BITS_DEF;
    localparam int PW       = PAYLOAD_BITS_DEF;
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int N_RANDOM = 450;
    localparam int DRAIN    = 8;

    typedef struct {
        t_op           op;
        logic [KW-1:0] key;
        logic [PW-1:0] pay;
        int            phase;
    } job_item_t;

    typedef struct packed {
        logic          job_valid;
        logic [KW-1:0] key;
        logic [PW-1:0] pay;
        logic [CW-1:0] entries;
        logic          is_empty;
        t_status       status;
    } job_result_t;

    logic          i_clk     = 1'b0;
    logic          i_rst_n   = 1'b0;
    logic          i_valid   = 1'b0;
    logic          i_ready   = 1'b0;
    logic [1:0]    i_op      = '0;
    logic [KW-1:0] i_key     = '0;
    logic [PW-1:0] i_payload = '0;
    logic          o_ready;
    logic          o_valid;
    logic          o_job_valid;
    logic [KW-1:0] o_job_key;
    logic [PW-1:0] o_job_payload;
    logic [CW-1:0] o_entries;
    logic          o_is_empty;
    logic [1:0]    o_status;

    fifo_and_sorted_insert_queue_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_job_valid   (o_job_valid),
        .o_job_key     (o_job_key),
        .o_job_payload (o_job_payload),
        .o_entries     (o_entries),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the job list, head in slot 0
    logic [KW-1:0] model_keys [DEPTH];
    logic [PW-1:0] model_pays [DEPTH];
    int            model_count = 0;

    job_item_t     pending_items[$];
    job_result_t   expected_results[$];

    int send_idle_pct[3]  = '{36, 59, 0};
    int recv_stall_pct[3] = '{59, 36, 0};
    int cur_phase         = 0;

    int n_errors     = 0;
    int n_checked    = 0;
    int n_full       = 0;
    int n_empty_err  = 0;
    int max_fill     = 0;
    int n_by_op[4]   = '{0, 0, 0, 0};

    function automatic job_result_t apply_queue_op(t_op op, logic [KW-1:0] key,
                                                   logic [PW-1:0] pay);
        job_result_t r;
        int          pos;
        r        = '0;
        r.status = ST_OK;
        n_by_op[op]++;
        case (op)
            OP_PUSH_TAIL, OP_PUSH_ORD: begin
                if (model_count >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    pos = model_count;
                    if (op == OP_PUSH_ORD) begin
                        for (int i = model_count - 1; i >= 0; i--)
                            if (key < model_keys[i]) pos = i;
                    end
                    for (int i = model_count; i > pos; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_pays[i] = model_pays[i-1];
                    end
                    model_keys[pos] = key;
                    model_pays[pos] = pay;
                    model_count++;
                    if (model_count > max_fill) max_fill = model_count;
                end
            end
            default: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty_err++;
                end else begin
                    r.job_valid = 1'b1;
                    r.key       = model_keys[0];
                    r.pay       = model_pays[0];
                    if (op == OP_POP) begin
                        for (int i = 1; i < model_count; i++) begin
                            model_keys[i-1] = model_keys[i];
                            model_pays[i-1] = model_pays[i];
                        end
                        model_count--;
                    end
                end
            end
        endcase
        r.entries  = CW'(model_count);
        r.is_empty = (model_count == 0);
        return r;
    endfunction

    task automatic report_error(string msg);
        n_errors++;
        if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic add_job(t_op op, logic [KW-1:0] key, logic [PW-1:0] pay, int phase);
        job_item_t it;
        it.op    = op;
        it.key   = key;
        it.pay   = pay;
        it.phase = phase;
        pending_items.push_back(it);
    endtask

    // sender
    always @(posedge i_clk) begin : drive_jobs
        job_item_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(apply_queue_op(t_op'(i_op), i_key, i_payload));
            if (!i_valid || o_ready) begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct[pending_items[0].phase]) begin
                    nxt = pending_items.pop_front();
                    cur_phase <= nxt.phase;
                    i_op      <= nxt.op;
                    i_key     <= nxt.key;
                    i_payload <= nxt.pay;
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : check_results
        job_result_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf(
                        "unexpected result: jv=%0d key=%h pay=%h ent=%0d st=%0d",
                        o_job_valid, o_job_key, o_job_payload, o_entries, o_status));
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (o_job_valid !== want.job_valid || o_job_key !== want.key ||
                        o_job_payload !== want.pay || o_entries !== want.entries ||
                        o_is_empty !== want.is_empty || o_status !== want.status)
                        report_error({
                            $sformatf("result %0d exp jv=%0d key=%h pay=%h ent=%0d emp=%0d st=%0d",
                                      n_checked, want.job_valid, want.key, want.pay,
                                      want.entries, want.is_empty, want.status),
                            $sformatf(", got jv=%0d key=%h pay=%h ent=%0d emp=%0d st=%0d",
                                      o_job_valid, o_job_key, o_job_payload,
                                      o_entries, o_is_empty, o_status)});
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct[cur_phase]);
        end
    end

    initial begin
        int            n_gen;
        int            mode;
        int            len;
        int            roll;
        int            phase;
        logic [KW-1:0] k;

        // empty errors, ordered insert at middle, tail, head, equal keys
        add_job(OP_READ,      16'h1111, 16'h2222, 0);
        add_job(OP_POP,       16'h3333, 16'h4444, 0);
        add_job(OP_PUSH_ORD,  16'h8000, 16'h0001, 0);
        add_job(OP_PUSH_ORD,  16'hFFFF, 16'hFFFF, 0);
        add_job(OP_PUSH_ORD,  16'h0000, 16'h0000, 0);
        add_job(OP_PUSH_ORD,  16'h8000, 16'hAAAA, 0);
        add_job(OP_PUSH_TAIL, 16'h0000, 16'h5555, 0);
        add_job(OP_READ,      16'h0000, 16'h0000, 0);
        // fill up
        for (int i = 0; i < 11; i++)
            add_job((i % 2) ? OP_PUSH_TAIL : OP_PUSH_ORD, 16'(i * 16'h1745),
                    16'(16'hF00D ^ (i << 4)), 0);
        add_job(OP_PUSH_TAIL, 16'h7777, 16'h7777, 0);
        add_job(OP_PUSH_ORD,  16'h0001, 16'h0001, 0);
        add_job(OP_READ,      16'h0000, 16'h0000, 0);
        add_job(OP_POP,       16'h0000, 16'h0000, 0);
        add_job(OP_POP,       16'h0000, 16'h0000, 0);

        // random bursts: push-heavy, pop-heavy and balanced
        n_gen = 0;
        while (n_gen < N_RANDOM) begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(8, 30);
            for (int j = 0; j < len && n_gen < N_RANDOM; j++) begin
                roll  = $urandom_range(0, 99);
                phase = (n_gen * 3) / N_RANDOM;
                case ($urandom_range(0, 9))
                    0, 1, 2: k = KW'($urandom_range(0, 7));
                    3:       k = $urandom_range(0, 1) ? '1 : '0;
                    default: k = KW'($urandom);
                endcase
                if ((mode == 0 && roll < 80) || (mode == 1 && roll < 20) ||
                    (mode == 2 && roll < 50))
                    add_job(($urandom_range(0, 99) < 65) ? OP_PUSH_ORD : OP_PUSH_TAIL,
                            k, PW'($urandom), phase);
                else
                    add_job(($urandom_range(0, 99) < 70) ? OP_POP : OP_READ,
                            k, PW'($urandom), phase);
                n_gen++;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Ran %0d items: %0d tail pushes, %0d ordered pushes, %0d pops, %0d reads",
                 n_checked, n_by_op[OP_PUSH_TAIL], n_by_op[OP_PUSH_ORD], n_by_op[OP_POP],
                 n_by_op[OP_READ]);
        $display("Full refusals %0d, empty errors %0d, highest fill %0d, mismatches %0d",
                 n_full, n_empty_err, max_fill, n_errors);
        if (n_errors == 0)
            $display("fifo_and_sorted_insert_queue_unit test passed");
        else
            $display("fifo_and_sorted_insert_queue_unit test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TIMEOUT");
        $display("fifo_and_sorted_insert_queue_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fsq_pkg.sv
hdl/fsq_cell.sv
hdl/fifo_and_sorted_insert_queue_unit.sv
tb/sv/tb_fifo_and_sorted_insert_queue_unit.sv
